// ===== design/vr_pkg.sv =====
package vr_pkg;

    // Bit widths used by the top level
    localparam int unsigned IN_W = 16;
    localparam int unsigned OUT_W = 16;

endpackage

// ===== design/vr_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Gives floor(num / den) in QW bits, saturated to SAT. A zero divisor gives SAT.
module vr_divider #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 16,
    parameter int unsigned QW = 18,
    parameter int unsigned TW = 8
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [QW-1:0] sat,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] tag_out
);
    localparam int unsigned RW = DW + 1;

    logic          v_reg [NW+1];
    logic [NW-1:0] n_reg [NW+1];
    logic [RW-1:0] r_reg [NW+1];
    logic [DW-1:0] d_reg [NW+1];
    logic [QW-1:0] s_reg [NW+1];
    logic [TW-1:0] t_reg [NW+1];

    // Stage zero takes the operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= num;
        r_reg[0] <= '0;
        d_reg[0] <= den;
        s_reg[0] <= sat;
        t_reg[0] <= tag_in;
    end

    // One shift-subtract step per stage; quotient bits shift into n_reg
    for (genvar g = 0; g < NW; g++)
    begin : g_step
        logic [RW:0]   sh;
        logic [RW:0]   df;
        logic          ge;
        always_comb
        begin
            sh = {r_reg[g], n_reg[g][NW-1]};
            df = sh - {2'b00, d_reg[g]};
            ge = !df[RW];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g+1] <= 1'b0;
            end
            else
            begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[g+1] <= ge ? df[RW-1:0] : sh[RW-1:0];
            n_reg[g+1] <= {n_reg[g][NW-2:0], ge};
            d_reg[g+1] <= d_reg[g];
            s_reg[g+1] <= s_reg[g];
            t_reg[g+1] <= t_reg[g];
        end
    end

    // Saturate the quotient
    logic [NW-1:0] q_full;
    always_comb
    begin
        q_full = n_reg[NW];
        if (d_reg[NW] == '0)
        begin
            quo = s_reg[NW];
        end
        else if (q_full > NW'(s_reg[NW]))
        begin
            quo = s_reg[NW];
        end
        else
        begin
            quo = q_full[QW-1:0];
        end
    end

    assign out_valid = v_reg[NW];
    assign tag_out = t_reg[NW];

endmodule

// ===== design/vr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Gives floor(sqrt(rad)) for an RW-bit radicand, SW = RW/2 result bits.
module vr_sqrt #(
    parameter int unsigned RW = 50,
    parameter int unsigned TW = 8
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [RW-1:0] rad,
    input  logic [TW-1:0] tag_in,
    output logic          out_valid,
    output logic [RW/2-1:0] root,
    output logic [TW-1:0] tag_out
);
    localparam int unsigned SW = RW / 2;
    localparam int unsigned AW = SW + 2;

    logic          v_reg [SW+1];
    logic [RW-1:0] x_reg [SW+1];
    logic [AW-1:0] a_reg [SW+1];
    logic [SW-1:0] q_reg [SW+1];
    logic [TW-1:0] t_reg [SW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= rad;
        a_reg[0] <= '0;
        q_reg[0] <= '0;
        t_reg[0] <= tag_in;
    end

    // Digit-by-digit method: two radicand bits in, one root bit out per stage
    for (genvar g = 0; g < SW; g++)
    begin : g_step
        logic [AW-1:0] acc;
        logic [AW-1:0] trial;
        logic [AW-1:0] df;
        logic          ok;
        always_comb
        begin
            acc = {a_reg[g][AW-3:0], x_reg[g][RW-1:RW-2]};
            trial = {q_reg[g], 2'b01};
            df = acc - trial;
            ok = (acc >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g+1] <= 1'b0;
            end
            else
            begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            a_reg[g+1] <= ok ? df : acc;
            x_reg[g+1] <= {x_reg[g][RW-3:0], 2'b00};
            q_reg[g+1] <= {q_reg[g][SW-2:0], ok};
            t_reg[g+1] <= t_reg[g];
        end
    end

    assign out_valid = v_reg[SW];
    assign root = q_reg[SW];
    assign tag_out = t_reg[SW];

endmodule

// ===== design/vector_refraction.sv =====
// Channel   | Direction | Handshake          | Payload
// command   | in        | start / busy       | ray_x/y/z, normal_x/y/z, index_from, index_to
// result    | out       | done (one cycle)   | out_x/y/z, reflected
//
// One ray is taken every clock; busy is never raised.
// From the accepting edge to done a ray passes through, in order:
// two input stages, the ratio divider (FRAC_BITS+17 stages), two square stages,
// the square root (FRAC_BITS+7 stages), then the product and output stages.
// Reset clears the valid bits only; the receiver cannot stall, so each result
// leaves on done as soon as it reaches the output stage.
module vector_refraction #(
    parameter int unsigned FRAC_BITS = 14
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] ray_x,
    input  logic signed [15:0] ray_y,
    input  logic signed [15:0] ray_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0] index_from,
    input  logic [15:0] index_to,
    output logic        done,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic        reflected
);
    localparam int unsigned F   = FRAC_BITS;
    localparam int unsigned IW  = vr_pkg::IN_W;
    localparam int unsigned OW  = vr_pkg::OUT_W;
    localparam int unsigned NW  = IW + F;        // divider numerator
    localparam int unsigned RTW = F + 3;         // ratio bits
    localparam int unsigned CW  = F + 3;         // c signed bits
    localparam int unsigned CMW = F + 2;         // |c| bits
    localparam int unsigned R2W = F + 6;         // r2 bits
    localparam int unsigned CSW = F + 4;         // csq bits
    localparam int unsigned DW  = F + 11;        // signed D bits, |D| < 2^(F+10)
    localparam int unsigned RCW = F + 5;         // ratio*|c| bits
    localparam int unsigned SQW = 2 * F + 12;    // sqrt radicand (even)
    localparam int unsigned SW  = SQW / 2;       // sqrt result bits
    localparam int unsigned MW  = SW + 3;        // signed m bits
    localparam int unsigned PW  = IW + F + 10;   // products and sums
    localparam int unsigned TW  = 6 * IW;        // vectors in the tag
    localparam logic [RTW-1:0] RATIO_MAX = {RTW{1'b1}};
    localparam logic signed [CW-1:0] COS_MAX = CW'((4 << F) - 1);

    assign busy = 1'b0;

    // ---- stage A: dot products, registered alongside the divider operands
    logic signed [2*IW+1:0] dot_reg;
    logic                   a_v_reg;
    logic [TW-1:0]          a_vec_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg <= (2*IW+2)'(ray_x * normal_x) + (2*IW+2)'(ray_y * normal_y)
                 + (2*IW+2)'(ray_z * normal_z);
        a_vec_reg <= {ray_x, ray_y, ray_z, normal_x, normal_y, normal_z};
    end

    // round half up and saturate c
    logic signed [2*IW+1:0] dot_rnd;
    logic signed [CW-1:0]   c_a;
    always_comb
    begin
        dot_rnd = (dot_reg + ((2*IW+2)'(1) <<< (F - 1))) >>> F;
        if (dot_rnd > (2*IW+2)'(COS_MAX))
        begin
            c_a = COS_MAX;
        end
        else if (dot_rnd < -(2*IW+2)'(COS_MAX))
        begin
            c_a = -COS_MAX;
        end
        else
        begin
            c_a = dot_rnd[CW-1:0];
        end
    end

    // ---- ratio divider; c and vectors ride in its tag
    logic           dv_v;
    logic [RTW-1:0] ratio_d;
    logic [TW+CW-1:0] dv_tag;
    logic signed [CW-1:0] c_dl_reg;
    always_ff @(posedge clk)
    begin
        c_dl_reg <= c_a;
    end

    logic a2_v_reg;
    logic [TW-1:0] a2_vec_reg;
    logic [NW-1:0] num_reg;
    logic [IW-1:0] den_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a2_v_reg <= 1'b0;
        end
        else
        begin
            a2_v_reg <= a_v_reg;
        end
    end

    logic [IW-1:0] num0_reg;
    logic [IW-1:0] den0_reg;
    always_ff @(posedge clk)
    begin
        num0_reg <= index_from;
        den0_reg <= index_to;
        num_reg <= {num0_reg, F'(0)};
        den_reg <= den0_reg;
        a2_vec_reg <= a_vec_reg;
    end

    vr_divider #(.NW(NW), .DW(IW), .QW(RTW), .TW(TW + CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (a2_v_reg),
        .num      (num_reg),
        .den      (den_reg),
        .sat      (RATIO_MAX),
        .tag_in   ({a2_vec_reg, c_dl_reg}),
        .out_valid(dv_v),
        .quo      (ratio_d),
        .tag_out  (dv_tag)
    );

    // ---- stage B: squares
    logic b_v_reg;
    logic [RTW-1:0] b_ratio_reg;
    logic signed [CW-1:0] b_c_reg;
    logic [TW-1:0] b_vec_reg;
    logic [2*RTW-1:0] b_rr_reg;
    logic [2*CMW-1:0] b_cc_reg;
    logic [CMW-1:0] b_cm_reg;
    logic [CMW-1:0] cmag_d;
    logic signed [CW-1:0] c_d;
    always_comb
    begin
        c_d = dv_tag[CW-1:0];
        cmag_d = c_d[CW-1] ? CMW'(-c_d) : CMW'(c_d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else
        begin
            b_v_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ratio_reg <= ratio_d;
        b_c_reg <= c_d;
        b_cm_reg <= cmag_d;
        b_vec_reg <= dv_tag[TW+CW-1:CW];
        b_rr_reg <= ratio_d * ratio_d;
        b_cc_reg <= cmag_d * cmag_d;
    end

    // ---- stage C: r2*csq, and ratio*|c|
    logic c_v_reg;
    logic [RTW-1:0] c_ratio_reg;
    logic signed [CW-1:0] c_c_reg;
    logic [TW-1:0] c_vec_reg;
    logic [R2W-1:0] c_r2_reg;
    logic [R2W+CSW-1:0] c_p_reg;
    logic [RTW+CMW-1:0] c_rc_reg;
    logic [R2W-1:0] r2_b;
    logic [CSW-1:0] csq_b;
    always_comb
    begin
        r2_b = R2W'(b_rr_reg >> F);
        csq_b = CSW'(b_cc_reg >> F);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_ratio_reg <= b_ratio_reg;
        c_c_reg <= b_c_reg;
        c_vec_reg <= b_vec_reg;
        c_r2_reg <= r2_b;
        c_p_reg <= r2_b * csq_b;
        c_rc_reg <= b_ratio_reg * b_cm_reg;
    end

    // ---- stage D: D and path choice, launch square root
    logic signed [DW-1:0] d_c;
    logic refl_c;
    always_comb
    begin
        d_c = DW'(c_p_reg >> F) - DW'(c_r2_reg) + DW'(1 << F);
        refl_c = (c_c_reg == '0) || (d_c <= 0);
    end

    logic [SQW-1:0] rad_c;
    assign rad_c = refl_c ? '0 : SQW'({d_c, F'(0)});

    localparam int unsigned ST = TW + CW + RTW + RCW + 1;
    logic sq_v;
    logic [SW-1:0] s_root;
    logic [ST-1:0] sq_tag;
    logic [RCW-1:0] rc_c;
    assign rc_c = RCW'(c_rc_reg >> F);

    vr_sqrt #(.RW(SQW), .TW(ST)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_v_reg),
        .rad      (rad_c),
        .tag_in   ({c_vec_reg, c_c_reg, c_ratio_reg, rc_c, refl_c}),
        .out_valid(sq_v),
        .root     (s_root),
        .tag_out  (sq_tag)
    );

    // ---- stage E: m and the per-component products
    logic refl_s;
    logic [RCW-1:0] rc_s;
    logic [RTW-1:0] ratio_s;
    logic signed [CW-1:0] c_s;
    logic signed [IW-1:0] rv [3];
    logic signed [IW-1:0] nv [3];
    logic signed [MW-1:0] m_s;
    always_comb
    begin
        refl_s = sq_tag[0];
        rc_s = sq_tag[RCW:1];
        ratio_s = sq_tag[RCW+RTW:RCW+1];
        c_s = sq_tag[RCW+RTW+CW:RCW+RTW+1];
        for (int i = 0; i < 3; i++)
        begin
            rv[i] = sq_tag[ST-1-IW*i -: IW];
            nv[i] = sq_tag[ST-1-IW*(i+3) -: IW];
        end
        if (c_s[CW-1])
        begin
            m_s = MW'(rc_s) - MW'(s_root);
        end
        else
        begin
            m_s = MW'(s_root) - MW'(rc_s);
        end
    end

    logic e_v_reg;
    logic e_refl_reg;
    logic signed [PW-1:0] e_a_reg [3];
    logic signed [PW-1:0] e_b_reg [3];
    logic signed [IW-1:0] e_r_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else
        begin
            e_v_reg <= sq_v;
        end
    end

    // refraction needs ratio*r and m*n; reflection needs 2c*n
    always_ff @(posedge clk)
    begin
        e_refl_reg <= refl_s;
        for (int i = 0; i < 3; i++)
        begin
            e_r_reg[i] <= rv[i];
            e_a_reg[i] <= refl_s ? '0 : PW'($signed({1'b0, ratio_s}) * rv[i]);
            e_b_reg[i] <= refl_s ? PW'((PW'(c_s) <<< 1) * PW'(nv[i]))
                                 : PW'(PW'(m_s) * PW'(nv[i]));
        end
    end

    // ---- stage F: round, combine, saturate
    logic signed [PW-1:0] sum_e [3];
    logic signed [PW-1:0] res_e [3];
    logic signed [OW-1:0] sat_e [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_e[i] = (e_a_reg[i] + e_b_reg[i] + (PW'(1) <<< (F - 1))) >>> F;
            res_e[i] = e_refl_reg ? (PW'(e_r_reg[i]) - sum_e[i]) : sum_e[i];
            if (res_e[i] > PW'(32767))
            begin
                sat_e[i] = 16'sh7fff;
            end
            else if (res_e[i] < -PW'(32768))
            begin
                sat_e[i] = -16'sh8000;
            end
            else
            begin
                sat_e[i] = res_e[i][OW-1:0];
            end
        end
    end

    logic done_reg;
    logic signed [OW-1:0] o_reg [3];
    logic refl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        refl_reg <= e_refl_reg;
        for (int i = 0; i < 3; i++)
        begin
            o_reg[i] <= sat_e[i];
        end
    end

    assign done = done_reg;
    assign out_x = o_reg[0];
    assign out_y = o_reg[1];
    assign out_z = o_reg[2];
    assign reflected = refl_reg;

endmodule
